### hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Word format, opcodes and the record that travels along the divider chain.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 18;
	localparam int DVD_W     = WORD_BITS + FRAC_BITS;
	localparam int DIV_CELLS = DVD_W;

	localparam logic [WORD_BITS-1:0] FRAC_MASK =
		{{(WORD_BITS - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
	localparam logic [WORD_BITS-1:0] ONE_VAL  = WORD_BITS'(1) << FRAC_BITS;
	localparam logic [WORD_BITS-1:0] HALF_VAL = WORD_BITS'(1) << (FRAC_BITS - 1);

	typedef enum logic [2:0] {
		OP_MUL   = 3'd0,
		OP_DIV   = 3'd1,
		OP_ABS   = 3'd2,
		OP_FRAC  = 3'd3,
		OP_FLOOR = 3'd4,
		OP_CEIL  = 3'd5,
		OP_ROUND = 3'd6
	} fpa_op_t;

	typedef struct packed {
		logic                 step;
		logic                 neg;
		logic                 dz;
		logic [DVD_W-1:0]     dividend;
		logic [WORD_BITS-1:0] divisor;
		logic [WORD_BITS-1:0] rem;
		logic [WORD_BITS-1:0] acc;
	} fpa_cell_t;

endpackage

### hdl/fpa_req_if.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU request channel
// Carries one opcode and two operands under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fpa_req_if;
	import fpa_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [2:0]                  opcode;
	logic signed [WORD_BITS-1:0] operand_a;
	logic signed [WORD_BITS-1:0] operand_b;

	modport source (output valid, opcode, operand_a, operand_b, input ready);
	modport sink (input valid, opcode, operand_a, operand_b, output ready);

endinterface

### hdl/fpa_rsp_if.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU response channel
// Carries one result and the divide-by-zero flag under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fpa_rsp_if;
	import fpa_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] result;
	logic                        divide_by_zero;

	modport source (output valid, result, divide_by_zero, input ready);
	modport sink (input valid, result, divide_by_zero, output ready);

endinterface

### hdl/fpa_prep.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU front stage
// Decodes the request, forms the product and the single-operand results, and
// prepares operand magnitudes and signs for the divider chain.
// ----------------------------------------------------------------------------
module fpa_prep (
	input  logic             clk,
	input  logic             arst_n,
	fpa_req_if.sink          req,
	output logic             vld_out,
	output fpa_pkg::fpa_cell_t cell_out,
	input  logic             down_ready
);
	import fpa_pkg::*;

	logic                          vld_s1;
	fpa_cell_t                     cell_s1;
	fpa_cell_t                     cell_d;
	logic signed [2*WORD_BITS-1:0] prod;
	logic [WORD_BITS-1:0]          a_u;
	logic [WORD_BITS-1:0]          b_u;
	logic [WORD_BITS-1:0]          mag_a;
	logic [WORD_BITS-1:0]          mag_b;
	logic [WORD_BITS-1:0]          frac_a;
	logic [WORD_BITS-1:0]          floor_a;
	logic [WORD_BITS-1:0]          ceil_a;
	logic [WORD_BITS-1:0]          round_a;
	logic                          up;
	logic                          dz;
	logic                          load;

	assign load      = !vld_s1 || down_ready;
	assign req.ready = load;

	assign prod = (2*WORD_BITS)'(req.operand_a) * (2*WORD_BITS)'(req.operand_b);

	always_comb begin
		a_u     = req.operand_a;
		b_u     = req.operand_b;
		mag_a   = a_u[WORD_BITS-1] ? (~a_u + WORD_BITS'(1)) : a_u;
		mag_b   = b_u[WORD_BITS-1] ? (~b_u + WORD_BITS'(1)) : b_u;
		frac_a  = mag_a & FRAC_MASK;
		floor_a = a_u & ~FRAC_MASK;
		ceil_a  = ((a_u & FRAC_MASK) == '0) ? a_u : (floor_a + ONE_VAL);
		up      = frac_a >= HALF_VAL;
		if (frac_a == '0) begin
			round_a = a_u;
		end else if (a_u[WORD_BITS-1]) begin
			round_a = up ? floor_a : ceil_a;
		end else begin
			round_a = up ? ceil_a : floor_a;
		end
		dz = 1'b0;

		cell_d          = '0;
		cell_d.dividend = {mag_a, FRAC_BITS'(0)};
		cell_d.divisor  = mag_b;

		unique case (fpa_op_t'(req.opcode))
			OP_MUL: begin
				cell_d.acc = prod[FRAC_BITS +: WORD_BITS];
			end
			OP_DIV: begin
				dz          = b_u == '0;
				cell_d.dz   = dz;
				cell_d.step = !dz;
				cell_d.neg  = !dz && (a_u[WORD_BITS-1] ^ b_u[WORD_BITS-1]);
			end
			OP_ABS: begin
				cell_d.acc = mag_a;
			end
			OP_FRAC: begin
				cell_d.acc = frac_a;
			end
			OP_FLOOR: begin
				cell_d.acc = floor_a;
			end
			OP_CEIL: begin
				cell_d.acc = ceil_a;
			end
			OP_ROUND: begin
				cell_d.acc = round_a;
			end
			default: begin
				cell_d.acc = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && req.valid) begin
			cell_s1 <= cell_d;
		end
	end

	assign vld_out  = vld_s1;
	assign cell_out = cell_s1;

endmodule

### hdl/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU divider cell
// One restoring division step: takes one dividend bit into the remainder and
// produces one quotient bit, then hands the record to the next cell.
// ----------------------------------------------------------------------------
module fpa_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_in,
	input  fpa_pkg::fpa_cell_t cell_in,
	output logic               up_ready,
	output logic               vld_out,
	output fpa_pkg::fpa_cell_t cell_out,
	input  logic               down_ready
);
	import fpa_pkg::*;

	logic                 vld_q;
	fpa_cell_t            cell_q;
	fpa_cell_t            cell_d;
	logic [WORD_BITS:0]   rem_sh;
	logic [WORD_BITS:0]   diff;
	logic                 fits;
	logic                 load;

	assign load     = !vld_q || down_ready;
	assign up_ready = load;

	always_comb begin
		rem_sh = {cell_in.rem, cell_in.dividend[DVD_W-1]};
		diff   = rem_sh - {1'b0, cell_in.divisor};
		fits   = rem_sh >= {1'b0, cell_in.divisor};
		cell_d = cell_in;
		if (cell_in.step) begin
			cell_d.rem      = fits ? diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
			cell_d.dividend = {cell_in.dividend[DVD_W-2:0], 1'b0};
			cell_d.acc      = {cell_in.acc[WORD_BITS-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (load && vld_in) begin
			cell_q <= cell_d;
		end
	end

	assign vld_out  = vld_q;
	assign cell_out = cell_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && cell_q.step |-> cell_q.rem < cell_q.divisor)
		else $error("Partial remainder is not below the divisor.");

	a_idle_rem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !cell_q.step |-> cell_q.rem == '0)
		else $error("Remainder changed on a request that does not divide.");

	a_dz_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && cell_q.dz |-> !cell_q.step && !cell_q.neg && cell_q.acc == '0)
		else $error("Division by zero entered the divider chain.");

endmodule

### hdl/fpa_post.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU output stage
// Applies the quotient sign and holds the response until it is taken.
// ----------------------------------------------------------------------------
module fpa_post (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_in,
	input  fpa_pkg::fpa_cell_t cell_in,
	output logic               up_ready,
	fpa_rsp_if.source          rsp
);
	import fpa_pkg::*;

	logic                 vld_q;
	logic [WORD_BITS-1:0] result_q;
	logic                 dz_q;
	logic                 load;

	assign load     = !vld_q || rsp.ready;
	assign up_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (load && vld_in) begin
			result_q <= cell_in.neg ? (~cell_in.acc + WORD_BITS'(1)) : cell_in.acc;
			dz_q     <= cell_in.dz;
		end
	end

	assign rsp.valid          = vld_q;
	assign rsp.result         = result_q;
	assign rsp.divide_by_zero = dz_q;

endmodule

### hdl/fixed_point_q14_18_alu.sv
// ----------------------------------------------------------------------------
// Signed Q14.18 fixed-point ALU
// Every request passes one front stage, 50 divider cells and one output stage.
// Throughput is one request per cycle unless rsp.ready stalls the chain; the
// 50-cell chain sets the latency and each stage moves when the next is free.
// The asynchronous active-low reset empties every stage; no data is cleared.
// ----------------------------------------------------------------------------
module fixed_point_q14_18_alu (
	input  logic     clk,
	input  logic     arst_n,
	fpa_req_if.sink  req,
	fpa_rsp_if.source rsp
);
	import fpa_pkg::*;

	logic      vld [0:DIV_CELLS];
	logic      rdy [0:DIV_CELLS];
	fpa_cell_t dat [0:DIV_CELLS];

	fpa_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.vld_out    (vld[0]),
		.cell_out   (dat[0]),
		.down_ready (rdy[0])
	);

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
		fpa_div_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.vld_in     (vld[i]),
			.cell_in    (dat[i]),
			.up_ready   (rdy[i]),
			.vld_out    (vld[i+1]),
			.cell_out   (dat[i+1]),
			.down_ready (rdy[i+1])
		);
	end

	fpa_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld[DIV_CELLS]),
		.cell_in  (dat[DIV_CELLS]),
		.up_ready (rdy[DIV_CELLS]),
		.rsp      (rsp)
	);

endmodule
